// ===== rtl/mtsl_pkg.sv =====
// Shared types and constants for the two-list merge block.
package mtsl_pkg;

    // Width of one stored element.
    localparam int unsigned VALUE_W = 32;

    // List selectors carried in which_list.
    localparam logic LIST_FIRST  = 1'b0;
    localparam logic LIST_SECOND = 1'b1;

    // One input transaction: a push to one list, or the finish command.
    typedef struct packed {
        logic                      which_list;
        logic signed [VALUE_W-1:0] value;
        logic                      finish;
    } in_item_t;

    // One output transaction: an element of the merged run.
    typedef struct packed {
        logic signed [VALUE_W-1:0] merged_value;
        logic                      last;
        logic                      empty_res;
        logic                      dropped;
    } out_item_t;

endpackage

// ===== rtl/mtsl_chan_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
interface mtsl_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/mtsl_store.sv =====
// One list store: a synchronous memory with one write port and one registered read port.
module mtsl_store #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5
) (
    input  logic                                clk,
    input  logic                                we,
    input  logic [AW-1:0]                       waddr,
    input  logic signed [mtsl_pkg::VALUE_W-1:0] wdata,
    input  logic                                re,
    input  logic [AW-1:0]                       raddr,
    output logic signed [mtsl_pkg::VALUE_W-1:0] rdata
);

    logic signed [mtsl_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [mtsl_pkg::VALUE_W-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port; the data register holds its value until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/mtsl_ctrl.sv =====
// Load and merge sequencer: fills the stores, then walks both heads and emits results.
module mtsl_ctrl #(
    parameter int unsigned DEPTH = 32,
    parameter int unsigned AW    = 5,
    parameter int unsigned CW    = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    mtsl_chan_if.sink                           items,
    mtsl_chan_if.source                         results,
    output logic                                a_we,
    output logic                                b_we,
    output logic [AW-1:0]                       waddr,
    output logic signed [mtsl_pkg::VALUE_W-1:0] wdata,
    output logic                                a_re,
    output logic [AW-1:0]                       a_raddr,
    input  logic signed [mtsl_pkg::VALUE_W-1:0] a_rdata,
    output logic                                b_re,
    output logic [AW-1:0]                       b_raddr,
    input  logic signed [mtsl_pkg::VALUE_W-1:0] b_rdata
);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_MERGE,
        ST_EMPTY
    } state_t;

    localparam logic [CW-1:0] FULL = CW'(DEPTH);

    state_t              state_reg, state_next;
    logic [CW-1:0]       cnt_a_reg, cnt_a_next;
    logic [CW-1:0]       cnt_b_reg, cnt_b_next;
    logic [CW-1:0]       i_reg, i_next;
    logic [CW-1:0]       j_reg, j_next;
    logic                ovf_reg, ovf_next;
    logic                drop_reg, drop_next;
    logic                out_valid_reg, out_valid_next;
    mtsl_pkg::out_item_t out_data_reg, out_data_next;

    logic                in_fire;
    logic                out_free;
    logic                a_left;
    logic                b_left;
    logic                take_a;
    logic [CW-1:0]       i_inc;
    logic [CW-1:0]       j_inc;
    logic                pick_last;

    assign in_fire  = items.valid && items.ready;
    assign out_free = !out_valid_reg || results.ready;

    assign items.ready   = (state_reg == ST_LOAD);
    assign results.valid = out_valid_reg;
    assign results.data  = out_data_reg;

    // Head selection: the first list wins only on strict less-than.
    assign a_left = (i_reg < cnt_a_reg);
    assign b_left = (j_reg < cnt_b_reg);
    assign take_a = a_left && (!b_left || (a_rdata < b_rdata));
    assign i_inc  = i_reg + 1'b1;
    assign j_inc  = j_reg + 1'b1;
    assign pick_last = take_a ? ((i_inc == cnt_a_reg) && !b_left)
                              : ((j_inc == cnt_b_reg) && !a_left);

    // Memory ports. Writes happen only while loading and reads only at finish or
    // while merging, so a read never overlaps a write to the same entry.
    always_comb
    begin
        a_we    = 1'b0;
        b_we    = 1'b0;
        waddr   = '0;
        wdata   = items.data.value;
        a_re    = 1'b0;
        b_re    = 1'b0;
        a_raddr = '0;
        b_raddr = '0;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && !items.data.finish)
                begin
                    if (items.data.which_list == mtsl_pkg::LIST_FIRST)
                    begin
                        a_we  = (cnt_a_reg != FULL);
                        waddr = cnt_a_reg[AW-1:0];
                    end
                    else
                    begin
                        b_we  = (cnt_b_reg != FULL);
                        waddr = cnt_b_reg[AW-1:0];
                    end
                end
                // Fetch both heads as the merge starts.
                if (in_fire && items.data.finish)
                begin
                    a_re = (cnt_a_reg != '0);
                    b_re = (cnt_b_reg != '0);
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    a_re    = take_a && (i_inc < cnt_a_reg);
                    a_raddr = i_inc[AW-1:0];
                    b_re    = !take_a && (j_inc < cnt_b_reg);
                    b_raddr = j_inc[AW-1:0];
                end
            end
            ST_EMPTY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // Next-state logic of the sequencer and the output register.
    always_comb
    begin
        state_next     = state_reg;
        cnt_a_next     = cnt_a_reg;
        cnt_b_next     = cnt_b_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        ovf_next       = ovf_reg;
        drop_next      = drop_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (items.data.finish)
                    begin
                        drop_next  = ovf_reg;
                        ovf_next   = 1'b0;
                        i_next     = '0;
                        j_next     = '0;
                        state_next = ((cnt_a_reg == '0) && (cnt_b_reg == '0)) ? ST_EMPTY
                                                                               : ST_MERGE;
                    end
                    else if (items.data.which_list == mtsl_pkg::LIST_FIRST)
                    begin
                        if (cnt_a_reg == FULL)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_a_next = cnt_a_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (cnt_b_reg == FULL)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            cnt_b_next = cnt_b_reg + 1'b1;
                        end
                    end
                end
            end
            ST_MERGE:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.merged_value = take_a ? a_rdata : b_rdata;
                    out_data_next.last         = pick_last;
                    out_data_next.empty_res    = 1'b0;
                    out_data_next.dropped      = drop_reg;
                    if (take_a)
                    begin
                        i_next = i_inc;
                    end
                    else
                    begin
                        j_next = j_inc;
                    end
                    if (pick_last)
                    begin
                        cnt_a_next = '0;
                        cnt_b_next = '0;
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.merged_value = '0;
                    out_data_next.last         = 1'b1;
                    out_data_next.empty_res    = 1'b1;
                    out_data_next.dropped      = drop_reg;
                    state_next                 = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_a_reg     <= '0;
            cnt_b_reg     <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            ovf_reg       <= 1'b0;
            drop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_a_reg     <= cnt_a_next;
            cnt_b_reg     <= cnt_b_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            ovf_reg       <= ovf_next;
            drop_reg      <= drop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result payload needs no reset.
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    // The fill counts never pass the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_a_reg <= FULL) && (cnt_b_reg <= FULL))
    else $error("mtsl_ctrl: fill count beyond depth");

    // While merging, the read positions stay within the filled entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> ((i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg)))
    else $error("mtsl_ctrl: read position beyond fill count");

    // While merging, at least one list still has an element to emit.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (a_left || b_left))
    else $error("mtsl_ctrl: merge running with both lists used up");

    // Loading the final result of a run returns the block to loading with empty stores.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg != ST_LOAD) && out_free) && ((state_reg == ST_EMPTY) || pick_last)
        |=> ((state_reg == ST_LOAD) && (cnt_a_reg == '0) && (cnt_b_reg == '0)
             && out_valid_reg && out_data_reg.last))
    else $error("mtsl_ctrl: run did not end cleanly");

endmodule

// ===== rtl/merge_two_sorted_lists.sv =====
// Top level of the two-list merge block.
//
// Each push transaction (finish low) writes the value to the tail of the chosen list;
// one push is accepted every cycle while the block is loading. A push to a full list is
// dropped and reported on the dropped flag of every result of the next run. A finish
// transaction starts the merge: results then leave at one per cycle while the output
// side takes them. When both lists are empty, the run yields a single result with
// empty_res set. The pace is set by the single read port of each list memory, whose
// registered data supplies one new head per cycle. The next transaction is taken as
// soon as the final result is in the output register, even while that result still
// waits to be taken. Both lists are emptied after each run.
module merge_two_sorted_lists #(
    parameter int unsigned DEPTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    mtsl_chan_if.sink   items,
    mtsl_chan_if.source results
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic                                a_we;
    logic                                b_we;
    logic [AW-1:0]                       waddr;
    logic signed [mtsl_pkg::VALUE_W-1:0] wdata;
    logic                                a_re;
    logic [AW-1:0]                       a_raddr;
    logic signed [mtsl_pkg::VALUE_W-1:0] a_rdata;
    logic                                b_re;
    logic [AW-1:0]                       b_raddr;
    logic signed [mtsl_pkg::VALUE_W-1:0] b_rdata;

    // Sequencer.
    mtsl_ctrl #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items),
        .results (results),
        .a_we    (a_we),
        .b_we    (b_we),
        .waddr   (waddr),
        .wdata   (wdata),
        .a_re    (a_re),
        .a_raddr (a_raddr),
        .a_rdata (a_rdata),
        .b_re    (b_re),
        .b_raddr (b_raddr),
        .b_rdata (b_rdata)
    );

    // Store of the first list.
    mtsl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_first_store (
        .clk   (clk),
        .we    (a_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (a_re),
        .raddr (a_raddr),
        .rdata (a_rdata)
    );

    // Store of the second list.
    mtsl_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_second_store (
        .clk   (clk),
        .we    (b_we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (b_re),
        .raddr (b_raddr),
        .rdata (b_rdata)
    );

endmodule
